### design/ata_pkg.sv
// Shared types, constants and helper functions for the tilt angle pipeline.
package ata_pkg;

   localparam int ANGLE_FRAC_BITS = 8;
   localparam int ACC_FRAC        = 20;
   localparam int SQRT_STAGES     = 32;
   localparam int CORDIC_STEPS    = 24;
   localparam int PIPE_DEPTH      = 1 + SQRT_STAGES + CORDIC_STEPS + 1;

   localparam int MAG_W  = 17;  // |sample|
   localparam int SUM_W  = 32;  // sum of two squares
   localparam int ROOT_W = 32;  // integer sqrt of (sum << 32)
   localparam int VEC_W  = 33;  // CORDIC input magnitude
   localparam int CXY_W  = 36;  // CORDIC x/y datapath
   localparam int ACC_W  = 29;  // angle accumulator, 2^-20 degree
   localparam int ANG_W  = 27;  // clamped angle magnitude

   localparam logic [ANG_W-1:0] DEG90_ACC = ANG_W'(90 * (1 << ACC_FRAC));
   localparam int RND_SHIFT = ACC_FRAC - ANGLE_FRAC_BITS;
   localparam logic [ANG_W-1:0] RND_HALF  = ANG_W'(1 << (RND_SHIFT - 1));
   localparam logic [ANG_W-1:0] FULL_OUT  = ANG_W'(90 * (1 << ANGLE_FRAC_BITS));

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] tilt_x;
      logic signed [15:0] tilt_y;
      logic signed [15:0] tilt_z;
      logic [2:0]         undefined_mask;
   } rsp_type;

   typedef struct packed {
      logic [2:0] neg;
      logic [2:0] num_zero;
      logic [2:0] den_zero;
   } flag_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag_x;
      logic [MAG_W-1:0] mag_y;
      logic [MAG_W-1:0] mag_z;
      flag_type         flags;
   } side_type;

   // atan(2^-k) in degrees, units of 2^-20 degree
   function automatic logic signed [ACC_W-1:0] atan_step(input int k);
      logic signed [ACC_W-1:0] v;
      case (k)
         0:  v = ACC_W'(47185920);
         1:  v = ACC_W'(27855475);
         2:  v = ACC_W'(14718068);
         3:  v = ACC_W'(7471121);
         4:  v = ACC_W'(3750058);
         5:  v = ACC_W'(1876857);
         6:  v = ACC_W'(938658);
         7:  v = ACC_W'(469357);
         8:  v = ACC_W'(234682);
         9:  v = ACC_W'(117342);
         10: v = ACC_W'(58671);
         11: v = ACC_W'(29335);
         12: v = ACC_W'(14668);
         13: v = ACC_W'(7334);
         14: v = ACC_W'(3667);
         15: v = ACC_W'(1833);
         16: v = ACC_W'(917);
         17: v = ACC_W'(458);
         18: v = ACC_W'(229);
         19: v = ACC_W'(115);
         20: v = ACC_W'(57);
         21: v = ACC_W'(29);
         22: v = ACC_W'(14);
         23: v = ACC_W'(7);
         default: v = '0;
      endcase
      return v;
   endfunction

   // clamp, round and sign one axis
   function automatic logic [15:0] finish_angle(input logic signed [ACC_W-1:0] acc,
                                                input logic num_zero,
                                                input logic den_zero,
                                                input logic neg);
      logic [ANG_W-1:0] a;
      logic [ANG_W-1:0] q;
      if (acc < 0)
         a = '0;
      else if (acc > $signed({2'b00, DEG90_ACC}))
         a = DEG90_ACC;
      else
         a = acc[ANG_W-1:0];
      if (den_zero)
         a = DEG90_ACC;
      q = (a + RND_HALF) >> RND_SHIFT;
      if (q > FULL_OUT)
         q = FULL_OUT;
      if (neg)
         q = ANG_W'(0) - q;
      if (num_zero)
         q = '0;
      return q[15:0];
   endfunction

endpackage

### design/ata_sqrt_pipe.sv
// Pipelined integer square root of (radicand << 32), one result bit per stage.
module ata_sqrt_pipe (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [ata_pkg::SUM_W-1:0]   rad,
   output logic [ata_pkg::ROOT_W-1:0]  root
);
   import ata_pkg::*;

   logic [SUM_W:0]    rem_ff  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_ff [SQRT_STAGES];
   logic [SUM_W-1:0]  bits_ff [SQRT_STAGES];
   logic [SUM_W:0]    rem_in  [SQRT_STAGES];
   logic [ROOT_W-1:0] root_in [SQRT_STAGES];
   logic [SUM_W-1:0]  bits_in [SQRT_STAGES];

   always_comb begin
      logic [SUM_W:0]    r;
      logic [ROOT_W-1:0] q;
      logic [SUM_W-1:0]  b;
      logic [SUM_W+2:0]  trial;
      for (int k = 0; k < SQRT_STAGES; k++) begin
         if (k == 0) begin
            r = '0;
            q = '0;
            b = rad;
         end else begin
            r = rem_ff[k-1];
            q = root_ff[k-1];
            b = bits_ff[k-1];
         end
         trial = {r, b[SUM_W-1 -: 2]} - {1'b0, q, 2'b01};
         if (!trial[SUM_W+2]) begin
            rem_in[k]  = trial[SUM_W:0];
            root_in[k] = {q[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = {r[SUM_W-2:0], b[SUM_W-1 -: 2]};
            root_in[k] = {q[ROOT_W-2:0], 1'b0};
         end
         bits_in[k] = {b[SUM_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < SQRT_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            bits_ff[k] <= bits_in[k];
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

### design/ata_cordic_pipe.sv
// Pipelined CORDIC vectoring: angle of (den, num) in 2^-20 degree units.
module ata_cordic_pipe (
   input  logic                               clock,
   input  logic                               advance,
   input  logic [ata_pkg::VEC_W-1:0]          den,
   input  logic [ata_pkg::VEC_W-1:0]          num,
   output logic signed [ata_pkg::ACC_W-1:0]   angle
);
   import ata_pkg::*;

   logic signed [CXY_W-1:0] cx_ff  [CORDIC_STEPS];
   logic signed [CXY_W-1:0] cy_ff  [CORDIC_STEPS];
   logic signed [ACC_W-1:0] acc_ff [CORDIC_STEPS];
   logic signed [CXY_W-1:0] cx_in  [CORDIC_STEPS];
   logic signed [CXY_W-1:0] cy_in  [CORDIC_STEPS];
   logic signed [ACC_W-1:0] acc_in [CORDIC_STEPS];

   always_comb begin
      logic signed [CXY_W-1:0] x;
      logic signed [CXY_W-1:0] y;
      logic signed [ACC_W-1:0] a;
      logic signed [CXY_W-1:0] dx;
      logic signed [CXY_W-1:0] dy;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         if (k == 0) begin
            x = $signed(CXY_W'(den));
            y = $signed(CXY_W'(num));
            a = '0;
         end else begin
            x = cx_ff[k-1];
            y = cy_ff[k-1];
            a = acc_ff[k-1];
         end
         dx = x >>> k;
         dy = y >>> k;
         // rotate toward the x axis
         if (y >= 0) begin
            cx_in[k]  = x + dy;
            cy_in[k]  = y - dx;
            acc_in[k] = a + atan_step(k);
         end else begin
            cx_in[k]  = x - dy;
            cy_in[k]  = y + dx;
            acc_in[k] = a - atan_step(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            cx_ff[k]  <= cx_in[k];
            cy_ff[k]  <= cy_in[k];
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   assign angle = acc_ff[CORDIC_STEPS-1];

endmodule

### design/accel_tilt_angles_core.sv
// Top level: accelerometer sample to three tilt angles, fully pipelined.
// Takes one sample per clock while the pipeline advances and returns its
// three tilt angles: a front register forms magnitudes and sums of squares,
// then 32 square-root stages (one root bit each), 24 CORDIC vectoring stages,
// and a final stage clamps, rounds and signs into the output register. The
// whole pipeline advances whenever the output register is empty or being taken,
// so with rsp_ready held high one beat enters and one leaves every cycle.
module accel_tilt_angles_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ata_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ata_pkg::rsp_type rsp_data
);
   import ata_pkg::*;

   logic                   advance;
   logic [PIPE_DEPTH-1:0]  vld_ff;
   logic [PIPE_DEPTH-1:0]  vld_in;

   logic [MAG_W-1:0] ax, ay, az;
   side_type         side_in;
   logic [SUM_W-1:0] sum_yz_ff, sum_xz_ff, sum_xy_ff;
   logic [SUM_W-1:0] sum_yz_in, sum_xz_in, sum_xy_in;
   side_type         front_ff;
   side_type         side_sq_ff [SQRT_STAGES];
   flag_type         flag_co_ff [CORDIC_STEPS];

   logic [ROOT_W-1:0]       r_yz, r_xz, r_xy;
   side_type                sq_side;
   logic signed [ACC_W-1:0] ang_x, ang_y, ang_z;
   flag_type                co_flags;
   rsp_type                 rsp_ff;
   rsp_type                 rsp_in;

   assign advance   = !vld_ff[PIPE_DEPTH-1] || rsp_ready;
   assign req_ready = advance;
   assign vld_in    = {vld_ff[PIPE_DEPTH-2:0], req_valid};

   function automatic logic [MAG_W-1:0] mag(input logic signed [15:0] v);
      logic [MAG_W-1:0] e;
      e = {v[15], v};
      return v[15] ? (MAG_W'(0) - e) : e;
   endfunction

   always_comb begin
      logic [SUM_W-1:0] sx, sy, sz;
      ax = mag(req_data.accel_x);
      ay = mag(req_data.accel_y);
      az = mag(req_data.accel_z);
      sx = SUM_W'(ax * ax);
      sy = SUM_W'(ay * ay);
      sz = SUM_W'(az * az);
      sum_yz_in = sy + sz;
      sum_xz_in = sx + sz;
      sum_xy_in = sx + sy;
      side_in.mag_x = ax;
      side_in.mag_y = ay;
      side_in.mag_z = az;
      side_in.flags.neg = {req_data.accel_z[15], req_data.accel_y[15], req_data.accel_x[15]};
      side_in.flags.num_zero = {(ax == '0) && (ay == '0), ay == '0, ax == '0};
      side_in.flags.den_zero = {az == '0, (ax == '0) && (az == '0), (ay == '0) && (az == '0)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         sum_yz_ff <= sum_yz_in;
         sum_xz_ff <= sum_xz_in;
         sum_xy_ff <= sum_xy_in;
         front_ff  <= side_in;
         side_sq_ff[0] <= front_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            side_sq_ff[k] <= side_sq_ff[k-1];
         end
         flag_co_ff[0] <= sq_side.flags;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            flag_co_ff[k] <= flag_co_ff[k-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   ata_sqrt_pipe u_sqrt_yz (.clock, .advance, .rad(sum_yz_ff), .root(r_yz));
   ata_sqrt_pipe u_sqrt_xz (.clock, .advance, .rad(sum_xz_ff), .root(r_xz));
   ata_sqrt_pipe u_sqrt_xy (.clock, .advance, .rad(sum_xy_ff), .root(r_xy));

   assign sq_side = side_sq_ff[SQRT_STAGES-1];

   ata_cordic_pipe u_cordic_x (
      .clock, .advance,
      .den  (VEC_W'(r_yz)),
      .num  ({sq_side.mag_x[VEC_W-17:0], 16'b0}),
      .angle(ang_x)
   );
   ata_cordic_pipe u_cordic_y (
      .clock, .advance,
      .den  (VEC_W'(r_xz)),
      .num  ({sq_side.mag_y[VEC_W-17:0], 16'b0}),
      .angle(ang_y)
   );
   ata_cordic_pipe u_cordic_z (
      .clock, .advance,
      .den  ({sq_side.mag_z[VEC_W-17:0], 16'b0}),
      .num  (VEC_W'(r_xy)),
      .angle(ang_z)
   );

   assign co_flags = flag_co_ff[CORDIC_STEPS-1];

   always_comb begin
      rsp_in.tilt_x = finish_angle(ang_x, co_flags.num_zero[0], co_flags.den_zero[0],
                                   co_flags.neg[0]);
      rsp_in.tilt_y = finish_angle(ang_y, co_flags.num_zero[1], co_flags.den_zero[1],
                                   co_flags.neg[1]);
      rsp_in.tilt_z = finish_angle(ang_z, co_flags.num_zero[2], co_flags.den_zero[2],
                                   co_flags.neg[2]);
      rsp_in.undefined_mask = co_flags.num_zero & co_flags.den_zero;
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_data  = rsp_ff;

endmodule

### dv/accel_tilt_angles_core_tb.sv
// Testbench for the tilt angle pipeline: drives accelerometer samples, checks angles.
`timescale 1ns / 100ps

module accel_tilt_angles_core_tb;
   import ata_pkg::*;

   localparam int NUM_RANDOM  = 1750;
   localparam int STALL_LIMIT = 20000;
   localparam int FRAC        = ANGLE_FRAC_BITS;

   localparam longint STEP_TABLE [24] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
      234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
      917, 458, 229, 115, 57, 29, 14, 7};

   // Integer floor square root, bit by bit.
   function automatic longint unsigned root_floor(input longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Angle of one axis with its flag; num and den are magnitudes with 16 frac bits.
   function automatic logic [15:0] axis_angle(input longint num, input longint den,
                                              input bit neg, output bit undef);
      longint cx, cy, acc, dx, dy, q;
      undef = 0;
      if (num == 0) begin
         undef = (den == 0);
         return '0;
      end
      if (den == 0) begin
         acc = longint'(90) << 20;
      end else begin
         cx = den;
         cy = num;
         acc = 0;
         for (int i = 0; i < 24; i++) begin
            dx = cx >>> i;
            dy = cy >>> i;
            if (cy >= 0) begin
               cx += dy; cy -= dx; acc += STEP_TABLE[i];
            end else begin
               cx -= dy; cy += dx; acc -= STEP_TABLE[i];
            end
         end
         if (acc < 0) acc = 0;
         if (acc > (longint'(90) << 20)) acc = longint'(90) << 20;
      end
      q = (acc + (longint'(1) << (20 - FRAC - 1))) >>> (20 - FRAC);
      if (q > (longint'(90) << FRAC)) q = longint'(90) << FRAC;
      if (neg) q = -q;
      return q[15:0];
   endfunction

   function automatic rsp_type tilt_of(input req_type s);
      rsp_type r;
      longint x, y, z, ax, ay, az, r_yz, r_xz, r_xy;
      bit ux, uy, uz;
      x = s.accel_x; y = s.accel_y; z = s.accel_z;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      az = z < 0 ? -z : z;
      r_yz = root_floor(longint'(y * y + z * z) << 32);
      r_xz = root_floor(longint'(x * x + z * z) << 32);
      r_xy = root_floor(longint'(x * x + y * y) << 32);
      r.tilt_x = axis_angle(ax << 16, r_yz, x < 0, ux);
      r.tilt_y = axis_angle(ay << 16, r_xz, y < 0, uy);
      r.tilt_z = axis_angle(r_xy, az << 16, z < 0, uz);
      r.undefined_mask = {uz, uy, ux};
      return r;
   endfunction

   class tilt_scoreboard;
      rsp_type pending_angles[$];
      int errors;
      int checked;

      function void note_sample(req_type s);
         pending_angles.push_back(tilt_of(s));
      endfunction

      function void check_angles(rsp_type got);
         rsp_type exp_r;
         if (pending_angles.size() == 0) begin
            $error("unexpected result beat %h", got);
            errors++;
            return;
         end
         exp_r = pending_angles.pop_front();
         checked++;
         if (got.tilt_x !== exp_r.tilt_x) begin
            $error("tilt_x exp %0d got %0d", exp_r.tilt_x, got.tilt_x); errors++;
         end
         if (got.tilt_y !== exp_r.tilt_y) begin
            $error("tilt_y exp %0d got %0d", exp_r.tilt_y, got.tilt_y); errors++;
         end
         if (got.tilt_z !== exp_r.tilt_z) begin
            $error("tilt_z exp %0d got %0d", exp_r.tilt_z, got.tilt_z); errors++;
         end
         if (got.undefined_mask !== exp_r.undefined_mask) begin
            $error("undefined_mask exp %0d got %0d", exp_r.undefined_mask,
                   got.undefined_mask);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   tilt_scoreboard sb;
   bit  sending_done;
   bit  quiet_phase;
   bit  hold_off;
   int  idle_cycles;

   accel_tilt_angles_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // Offer one sample and hold it until taken, with an optional idle burst first.
   task automatic send_sample(input req_type s);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_sample(s);
   endtask

   function automatic logic signed [15:0] edge_value();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'sh0001;
         4: return 16'shffff;
         5: return 16'(signed'($urandom_range(0, 64)) - 32);
         default: return 16'($urandom);
      endcase
   endfunction

   // Sample stimulus.
   initial begin
      req_type s;
      logic signed [15:0] corners [8];
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      quiet_phase = 0;
      sending_done = 0;
      corners = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff,
                  16'sh4000, 16'shc000, 16'sh0100};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // zero over zero, single axes, extremes
      s = '{16'sd0, 16'sd0, 16'sd0};                      send_sample(s);
      s = '{16'sd100, 16'sd0, 16'sd0};                    send_sample(s);
      s = '{-16'sd100, 16'sd0, 16'sd0};                   send_sample(s);
      s = '{16'sd0, 16'sd7, 16'sd0};                      send_sample(s);
      s = '{16'sd0, -16'sd7, 16'sd0};                     send_sample(s);
      s = '{16'sd0, 16'sd0, 16'sd500};                    send_sample(s);
      s = '{16'sd0, 16'sd0, -16'sd500};                   send_sample(s);
      s = '{16'sh8000, 16'sh8000, 16'sh8000};             send_sample(s);
      s = '{16'sh7fff, 16'sh7fff, 16'sh7fff};             send_sample(s);
      s = '{16'sh8000, 16'sh7fff, 16'sh0000};             send_sample(s);
      s = '{16'sh0001, 16'sh0000, 16'sh7fff};             send_sample(s);
      s = '{16'shffff, 16'sh8000, 16'sh0001};             send_sample(s);
      s = '{16'sd1, 16'sd1, 16'sd1};                      send_sample(s);
      s = '{-16'sd1, -16'sd1, -16'sd1};                   send_sample(s);
      for (int i = 0; i < 8; i++) begin
         s = '{corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]};
         send_sample(s);
      end
      for (int n = 0; n < NUM_RANDOM; n++) begin
         if (n == NUM_RANDOM - 200) quiet_phase = 1;
         if ($urandom_range(0, 3) == 0)
            s = '{edge_value(), edge_value(), edge_value()};
         else
            s = '{16'($urandom), 16'($urandom), 16'($urandom)};
         send_sample(s);
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   // Result side: random stalls, one long hold-off to fill the pipeline.
   initial begin
      rsp_ready = 1'b0;
      hold_off = 0;
      @(negedge reset);
      for (int beat = 0; ; beat++) begin
         if (beat == 300) begin
            hold_off = 1;
            rsp_ready <= 1'b0;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_angles(rsp_data);
      end
   end

   // Watchdog and end of run.
   initial begin
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || hold_off)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (sending_done && sb.pending_angles.size() == 0) begin
            repeat (80) @(posedge clock);
            $display("Checked %0d tilt results from %0d directed and random samples.",
                     sb.checked, 22 + NUM_RANDOM);
            if (sb.errors == 0 && sb.pending_angles.size() == 0)
               $display("PASS");
            else
               $display("FAIL");
            $finish;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timed out with %0d results outstanding.", sb.pending_angles.size());
            $display("FAIL");
            $finish;
         end
      end
   end

endmodule

### accel_tilt_angles_core.f
design/ata_pkg.sv
design/ata_sqrt_pipe.sv
design/ata_cordic_pipe.sv
design/accel_tilt_angles_core.sv
dv/accel_tilt_angles_core_tb.sv
